### rtl/smae_pkg.sv
// ----------------------------------------------------------------------------
// smae_pkg
// Shared types, codes, widths and saturating arithmetic helpers for the
// small matrix arithmetic engine.
// ----------------------------------------------------------------------------
package smae_pkg;

    // Default values of the top level parameters.
    localparam int MAX_DIM_DEF   = 4;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths of the beats.
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;
    localparam int CMD_W      = 2;
    localparam int POS_W      = 2;
    localparam int DIM_REG_W  = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // Operation selected by the mode register.
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD       = 2'd0,
        MODE_SUB       = 2'd1,
        MODE_MUL       = 2'd2,
        MODE_TRANSPOSE = 2'd3
    } t_op_mode;

    // Input beat commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_RUN     = 2'd2,
        CMD_NOP     = 2'd3
    } t_command;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OP_MODE     = 2'd0,
        REG_ROWS_FIRST  = 2'd1,
        REG_COLS_FIRST  = 2'd2,
        REG_COLS_SECOND = 2'd3
    } t_cfg_index;

    // Reset values of the configuration registers.
    localparam t_op_mode              OP_MODE_RST = MODE_MUL;
    localparam logic [DIM_REG_W-1:0]  DIM_RST     = 3'd4;

    // Signed 64-bit addition that clamps on overflow.
    function automatic logic signed [ACC_W-1:0] sat_add64(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W-1:0] sum;
        sum = a + b;
        if ((a[ACC_W-1] == b[ACC_W-1]) && (sum[ACC_W-1] != a[ACC_W-1])) begin
            if (a[ACC_W-1]) begin
                sum = {1'b1, {(ACC_W-1){1'b0}}};
            end else begin
                sum = {1'b0, {(ACC_W-1){1'b1}}};
            end
        end
        return sum;
    endfunction

    // Clamp a signed 64-bit value into the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] sat32(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [DATA_W-1:0] res;
        if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
            res = v[DATA_W-1:0];
        end else if (v[ACC_W-1]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

### rtl/small_matrix_arith_engine.sv
// ----------------------------------------------------------------------------
// small_matrix_arith_engine
// Two element stores and a sequencer around one shared multiplier and one
// saturating accumulator; computes A+B, A-B, A*B or the transpose of A.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  input    | i_in_valid / o_in_stall    | command, elem_row, elem_col, value
//  output   | o_out_valid / i_out_stall  | result_value, row, col, last
//  config   | i_cfg_wr_en                | i_cfg_index, i_cfg_data
//
//  An element write beat is taken whenever the sequencer is idle, and the next
//  beat follows at once. Add, subtract and transpose read, combine and output
//  each result element; multiply takes one store read, one product and one
//  accumulate per term, bound by the single multiplier, then rounds and outputs.
//  Synchronous reset clears the sequencer, the output valid and the configuration
//  registers; the stores keep no reset value and must be written before they are used.
//  A stalled output beat holds the sequencer; the input stays stalled during
//  a run and is released once the last result sits in the output register.
// ----------------------------------------------------------------------------
module small_matrix_arith_engine #(
    parameter int MAX_DIM   = smae_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = smae_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [smae_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smae_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [smae_pkg::CMD_W-1:0]          i_command,
    input  logic [smae_pkg::POS_W-1:0]          i_elem_row,
    input  logic [smae_pkg::POS_W-1:0]          i_elem_col,
    input  logic signed [smae_pkg::DATA_W-1:0]  i_element_value,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [smae_pkg::DATA_W-1:0]  o_result_value,
    output logic [smae_pkg::POS_W-1:0]          o_result_row,
    output logic [smae_pkg::POS_W-1:0]          o_result_col,
    output logic                                o_last
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic signed [smae_pkg::ACC_W-1:0] ROUND_HALF =
        (64'sd1 <<< FRAC_BITS) >>> 1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_READ = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_ACC  = 6'b001000,
        ST_RND  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    // Last valid index of a dimension register: zero acts as one, large
    // values act as the maximum dimension.
    function automatic logic [IDX_W-1:0] last_idx(
        input logic [smae_pkg::DIM_REG_W-1:0] d
    );
        logic [IDX_W-1:0] res;
        if (d == '0) begin
            res = '0;
        end else if (int'(d) >= MAX_DIM) begin
            res = IDX_W'(MAX_DIM - 1);
        end else begin
            res = IDX_W'(d - 3'd1);
        end
        return res;
    endfunction

    // Store address of a row and column.
    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [IDX_W-1:0] r,
        input logic [IDX_W-1:0] c
    );
        return ADDR_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // Configuration registers
    smae_pkg::t_op_mode               r_op_mode;
    logic [smae_pkg::DIM_REG_W-1:0]   r_rows_first;
    logic [smae_pkg::DIM_REG_W-1:0]   r_cols_first;
    logic [smae_pkg::DIM_REG_W-1:0]   r_cols_second;

    // Sequencer
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_i, n_i;
    logic [IDX_W-1:0]    r_j, n_j;
    logic [IDX_W-1:0]    r_k, n_k;

    // Stores and datapath
    logic signed [smae_pkg::DATA_W-1:0] r_mem_a [DEPTH];
    logic signed [smae_pkg::DATA_W-1:0] r_mem_b [DEPTH];
    logic signed [smae_pkg::DATA_W-1:0] r_rd_a;
    logic signed [smae_pkg::DATA_W-1:0] r_rd_b;
    logic signed [smae_pkg::ACC_W-1:0]  r_prod;
    logic signed [smae_pkg::ACC_W-1:0]  r_acc;
    logic signed [smae_pkg::DATA_W-1:0] r_res;

    logic                  r_out_valid;
    logic                  in_take;
    logic                  out_free;
    logic                  out_load;
    logic                  elem_last;
    logic                  wr_in_range;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr_a;
    logic [ADDR_W-1:0]     rd_addr_b;
    logic [IDX_W-1:0]      nr_m1;
    logic [IDX_W-1:0]      nc_m1;
    logic [IDX_W-1:0]      inner_m1;
    logic signed [smae_pkg::DATA_W:0]   addsub;
    logic signed [smae_pkg::ACC_W-1:0]  acc_base;
    logic signed [smae_pkg::ACC_W-1:0]  rounded;
    logic signed [smae_pkg::ACC_W-1:0]  shifted;

    // Handshake decode
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == ST_OUT) && out_free;
    assign o_out_valid = r_out_valid;

    // Result shape per mode
    always_comb begin
        inner_m1 = last_idx(r_cols_first);
        case (r_op_mode)
            smae_pkg::MODE_MUL: begin
                nr_m1 = last_idx(r_rows_first);
                nc_m1 = last_idx(r_cols_second);
            end
            smae_pkg::MODE_TRANSPOSE: begin
                nr_m1 = last_idx(r_cols_first);
                nc_m1 = last_idx(r_rows_first);
            end
            default: begin
                nr_m1 = last_idx(r_rows_first);
                nc_m1 = last_idx(r_cols_first);
            end
        endcase
    end

    assign elem_last = (r_i == nr_m1) && (r_j == nc_m1);

    // Store read addresses follow the operation's indexing.
    always_comb begin
        case (r_op_mode)
            smae_pkg::MODE_MUL: begin
                rd_addr_a = store_addr(r_i, r_k);
                rd_addr_b = store_addr(r_k, r_j);
            end
            smae_pkg::MODE_TRANSPOSE: begin
                rd_addr_a = store_addr(r_j, r_i);
                rd_addr_b = store_addr(r_j, r_i);
            end
            default: begin
                rd_addr_a = store_addr(r_i, r_j);
                rd_addr_b = store_addr(r_i, r_j);
            end
        endcase
    end

    // Element write decode; writes outside the store are dropped.
    assign wr_in_range = (int'(i_elem_row) < MAX_DIM) && (int'(i_elem_col) < MAX_DIM);
    assign wr_addr     = ADDR_W'(int'(i_elem_row) * MAX_DIM + int'(i_elem_col));

    // Element stores with registered read data
    always_ff @(posedge i_clk) begin
        if (in_take && wr_in_range && (i_command == smae_pkg::CMD_WRITE_A)) begin
            r_mem_a[wr_addr] <= i_element_value;
        end
        if (in_take && wr_in_range && (i_command == smae_pkg::CMD_WRITE_B)) begin
            r_mem_b[wr_addr] <= i_element_value;
        end
        r_rd_a <= r_mem_a[rd_addr_a];
        r_rd_b <= r_mem_b[rd_addr_b];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode     <= smae_pkg::OP_MODE_RST;
            r_rows_first  <= smae_pkg::DIM_RST;
            r_cols_first  <= smae_pkg::DIM_RST;
            r_cols_second <= smae_pkg::DIM_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                smae_pkg::REG_OP_MODE:
                    r_op_mode <= smae_pkg::t_op_mode'(i_cfg_data[smae_pkg::MODE_W-1:0]);
                smae_pkg::REG_ROWS_FIRST:  r_rows_first  <= i_cfg_data;
                smae_pkg::REG_COLS_FIRST:  r_cols_first  <= i_cfg_data;
                smae_pkg::REG_COLS_SECOND: r_cols_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            ST_IDLE: begin
                if (in_take && (i_command == smae_pkg::CMD_RUN)) begin
                    n_state = ST_READ;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            ST_READ: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = (r_op_mode == smae_pkg::MODE_MUL) ? ST_ACC : ST_OUT;
            end
            ST_ACC: begin
                if (r_k == inner_m1) begin
                    n_state = ST_RND;
                end else begin
                    n_state = ST_READ;
                    n_k     = r_k + 1'b1;
                end
            end
            ST_RND: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_k = '0;
                    if (elem_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_READ;
                        if (r_j == nc_m1) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // Shared arithmetic: sum or difference, product, accumulate and rounding.
    assign addsub   = (r_op_mode == smae_pkg::MODE_SUB) ?
                      ($signed({r_rd_a[smae_pkg::DATA_W-1], r_rd_a}) -
                       $signed({r_rd_b[smae_pkg::DATA_W-1], r_rd_b})) :
                      ($signed({r_rd_a[smae_pkg::DATA_W-1], r_rd_a}) +
                       $signed({r_rd_b[smae_pkg::DATA_W-1], r_rd_b}));
    assign acc_base = (r_k == '0) ? '0 : r_acc;
    assign rounded  = smae_pkg::sat_add64(r_acc, ROUND_HALF);
    assign shifted  = rounded >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_MUL: begin
                r_prod <= r_rd_a * r_rd_b;
                if (r_op_mode == smae_pkg::MODE_TRANSPOSE) begin
                    r_res <= r_rd_a;
                end else begin
                    r_res <= smae_pkg::sat32(smae_pkg::ACC_W'(addsub));
                end
            end
            ST_ACC: begin
                r_acc <= smae_pkg::sat_add64(acc_base, r_prod);
            end
            ST_RND: begin
                r_res <= smae_pkg::sat32(shifted);
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_result_value <= r_res;
            o_result_row   <= smae_pkg::POS_W'(r_i);
            o_result_col   <= smae_pkg::POS_W'(r_j);
            o_last         <= elem_last;
        end
    end

endmodule
